// ===== rtl/tnpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tnpt_pkg
// Shared types and constants of the top-N peak table with period folding.
// ----------------------------------------------------------------------------
package tnpt_pkg;

  // Field widths of one request beat and one result beat.
  localparam int unsigned TimeW   = 24;
  localparam int unsigned PowerW  = 32;
  localparam int unsigned IndexW  = 8;
  localparam int unsigned ReqW    = 2;
  localparam int unsigned CountW  = 9;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned WindowW = 16;
  localparam int unsigned EntryW  = TimeW + PowerW;

  // Table depth default.
  localparam int unsigned DefaultMaxPeaks = 8;

  // Configuration register indexes and reset values.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_PERIOD_LEN = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_DUP_WINDOW = 1'd1;
  localparam logic [PeriodW-1:0] PeriodReset    = 16'd7488;
  localparam logic [WindowW-1:0] WindowReset    = 16'd58;

  // Request codes; the unused code behaves as a read.
  localparam logic [ReqW-1:0] REQ_OFFER = 2'd0;
  localparam logic [ReqW-1:0] REQ_READ  = 2'd1;
  localparam logic [ReqW-1:0] REQ_CLEAR = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NEW_DIV,
    ST_SCAN_RD,
    ST_SCAN_LD,
    ST_SCAN_DIV,
    ST_SCAN_CMP,
    ST_DECIDE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INSERT,
    ST_OUT_RD,
    ST_OUT_LD
  } state_e;

  // Control handed to the shared folding unit.
  typedef struct packed {
    logic               start;
    logic [TimeW-1:0]   dividend;
    logic [PeriodW-1:0] divisor;
  } div_req_t;

endpackage

// ===== rtl/tnpt_ram.sv =====
// ----------------------------------------------------------------------------
// tnpt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tnpt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/tnpt_div.sv =====
// ----------------------------------------------------------------------------
// tnpt_div
// Shared folding unit: residue of a time modulo the period, one bit a cycle.
// ----------------------------------------------------------------------------
module tnpt_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tnpt_pkg::div_req_t      req_i,
  output logic                    busy_o,
  output logic [tnpt_pkg::TimeW-1:0] residue_o
);

  localparam int unsigned StepW = $clog2(tnpt_pkg::TimeW);

  logic                           busy_q, busy_d;
  logic [StepW-1:0]               step_q, step_d;
  logic                           bypass_q, bypass_d;
  logic [tnpt_pkg::TimeW-1:0]     dvd_q, dvd_d;
  logic [tnpt_pkg::PeriodW-1:0]   dvs_q, dvs_d;
  logic [tnpt_pkg::PeriodW-1:0]   rem_q, rem_d;
  logic [tnpt_pkg::PeriodW:0]     rem_sh;
  logic [tnpt_pkg::PeriodW:0]     rem_sub;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign rem_sh  = {rem_q, dvd_q[tnpt_pkg::TimeW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d   = busy_q;
    step_d   = step_q;
    bypass_d = bypass_q;
    dvd_d    = dvd_q;
    dvs_d    = dvs_q;
    rem_d    = rem_q;
    if (req_i.start) begin
      // A zero period leaves the time unreduced.
      dvd_d    = req_i.dividend;
      dvs_d    = req_i.divisor;
      rem_d    = '0;
      step_d   = '0;
      bypass_d = (req_i.divisor == '0);
      busy_d   = (req_i.divisor != '0);
    end else if (busy_q) begin
      dvd_d = {dvd_q[tnpt_pkg::TimeW-2:0], 1'b0};
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sub[tnpt_pkg::PeriodW-1:0];
      end else begin
        rem_d = rem_sh[tnpt_pkg::PeriodW-1:0];
      end
      if (step_q == StepW'(tnpt_pkg::TimeW - 1)) begin
        busy_d = 1'b0;
      end else begin
        step_d = step_q + StepW'(1);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      step_q   <= '0;
      bypass_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      step_q   <= step_d;
      bypass_q <= bypass_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign busy_o    = busy_q;
  assign residue_o = bypass_q ? dvd_q : tnpt_pkg::TimeW'(rem_q);

endmodule

// ===== rtl/top_n_peak_table_with_period_dedup_unit.sv =====
// ----------------------------------------------------------------------------
// top_n_peak_table_with_period_dedup_unit
// Top-N peak table sorted by power, with period-folded duplicate removal.
// ----------------------------------------------------------------------------
// Each request beat gives exactly one result beat. A read or clear passes
// through a RAM read state and a load state; its result is registered once
// the result register is free or being emptied. An offer folds its time and
// then every held entry through one shared bit-serial modulo unit: it folds
// the new time, reads and folds each held entry and compacts the kept ones,
// closes the scan and decides, then, if the peak goes in, moves the entries
// below its place down one by one and writes the new peak, and last reads
// back the requested entry. With a zero period the fold is bypassed and the
// time is used unreduced. The table is kept in one RAM that is read and
// written one entry a cycle; it needs no clearing pass after reset. A result
// waits in an output register, so the next request is taken while the
// previous result is still unread.
// ----------------------------------------------------------------------------
module top_n_peak_table_with_period_dedup_unit #(
  parameter int unsigned MaxPeaks = tnpt_pkg::DefaultMaxPeaks
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tnpt_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [tnpt_pkg::PeriodW-1:0]    cfg_data_i,
  // Request channel.
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [tnpt_pkg::ReqW-1:0]       req_type_i,
  input  logic [tnpt_pkg::TimeW-1:0]      peak_time_i,
  input  logic [tnpt_pkg::PowerW-1:0]     peak_power_i,
  input  logic [tnpt_pkg::IndexW-1:0]     read_index_i,
  // Result channel.
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [tnpt_pkg::TimeW-1:0]      entry_time_o,
  output logic [tnpt_pkg::PowerW-1:0]     entry_power_o,
  output logic                            entry_valid_o,
  output logic [tnpt_pkg::CountW-1:0]     entry_count_o,
  output logic                            peak_inserted_o,
  output logic [tnpt_pkg::CountW-1:0]     peaks_removed_o
);

  localparam int unsigned IdxW = (MaxPeaks > 1) ? $clog2(MaxPeaks) : 1;
  localparam int unsigned CntW = $clog2(MaxPeaks + 1);
  localparam logic [CntW-1:0] CntMax  = CntW'(MaxPeaks);
  localparam logic [CntW-1:0] CntLast = CntW'(MaxPeaks - 1);

  tnpt_pkg::state_e state_q, state_d;

  // Configuration.
  logic [tnpt_pkg::PeriodW-1:0] period_q;
  logic [tnpt_pkg::WindowW-1:0] window_q;

  // Latched request.
  logic [tnpt_pkg::ReqW-1:0]   req_q;
  logic [tnpt_pkg::TimeW-1:0]  t_q;
  logic [tnpt_pkg::PowerW-1:0] p_q;
  logic [tnpt_pkg::IndexW-1:0] idx_q;

  // Scan and insertion state.
  logic [tnpt_pkg::TimeW-1:0]  rn_q, rn_d;
  logic [tnpt_pkg::TimeW-1:0]  cur_t_q, cur_t_d;
  logic [tnpt_pkg::PowerW-1:0] cur_p_q, cur_p_d;
  logic [CntW-1:0] i_q, i_d, kept_q, kept_d, gone_q, gone_d;
  logic [CntW-1:0] pos_q, pos_d, j_q, j_d, count_q, count_d;
  logic [CntW-1:0] j_prev, pos_eff;
  logic            found_q, found_d, stronger_q, stronger_d, ins_q, ins_d;

  // Result register.
  logic                        out_valid_q, out_valid_d, out_load;
  logic [tnpt_pkg::TimeW-1:0]  ot_q;
  logic [tnpt_pkg::PowerW-1:0] op_q;
  logic                        ov_q, oi_q;
  logic [tnpt_pkg::CountW-1:0] oc_q, or_q;

  // Table RAM.
  logic                           ram_we;
  logic [IdxW-1:0]                ram_waddr, ram_raddr;
  logic [tnpt_pkg::EntryW-1:0]    ram_wdata, ram_rdata;
  logic [tnpt_pkg::TimeW-1:0]     rd_time;
  logic [tnpt_pkg::PowerW-1:0]    rd_power;

  // Folding unit.
  tnpt_pkg::div_req_t             div_req;
  logic                           div_busy;
  logic [tnpt_pkg::TimeW-1:0]     div_res;

  // Compare terms.
  logic [tnpt_pkg::TimeW-1:0]     res_gap;
  logic                           is_dup, cur_stronger, new_stronger, rd_valid;
  logic                           in_fire;

  tnpt_ram #(
    .Width (tnpt_pkg::EntryW),
    .Depth (MaxPeaks)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tnpt_div u_fold (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (div_req),
    .busy_o    (div_busy),
    .residue_o (div_res)
  );

  assign rd_time  = ram_rdata[tnpt_pkg::EntryW-1 -: tnpt_pkg::TimeW];
  assign rd_power = ram_rdata[tnpt_pkg::PowerW-1:0];

  // Residue distance, duplicate test and power compares.
  assign res_gap      = (div_res >= rn_q) ? (div_res - rn_q) : (rn_q - div_res);
  assign is_dup       = (res_gap <= tnpt_pkg::TimeW'(window_q));
  assign cur_stronger = (cur_p_q > p_q);
  assign new_stronger = (p_q > cur_p_q);
  assign rd_valid     = ({1'b0, idx_q} < tnpt_pkg::CountW'(count_q));
  assign j_prev       = j_q - CntW'(1);
  assign pos_eff      = found_q ? pos_q : kept_q;
  assign in_fire      = in_valid_i & in_ready_o;

  // Sequencer: next state, counters and RAM and fold control.
  always_comb begin
    state_d      = state_q;
    rn_d         = rn_q;
    cur_t_d      = cur_t_q;
    cur_p_d      = cur_p_q;
    i_d          = i_q;
    kept_d       = kept_q;
    gone_d       = gone_q;
    pos_d        = pos_q;
    j_d          = j_q;
    count_d      = count_q;
    found_d      = found_q;
    stronger_d   = stronger_q;
    ins_d        = ins_q;
    out_load     = 1'b0;
    in_ready_o   = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_raddr    = idx_q[IdxW-1:0];
    div_req.start    = 1'b0;
    div_req.dividend = peak_time_i;
    div_req.divisor  = period_q;

    unique case (state_q)
      tnpt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ins_d  = 1'b0;
          gone_d = '0;
          if (req_type_i == tnpt_pkg::REQ_OFFER) begin
            div_req.start = 1'b1;
            i_d        = '0;
            kept_d     = '0;
            found_d    = 1'b0;
            stronger_d = 1'b0;
            state_d    = tnpt_pkg::ST_NEW_DIV;
          end else begin
            if (req_type_i == tnpt_pkg::REQ_CLEAR) begin
              count_d = '0;
            end
            state_d = tnpt_pkg::ST_OUT_RD;
          end
        end
      end

      tnpt_pkg::ST_NEW_DIV: begin
        if (!div_busy) begin
          rn_d    = div_res;
          state_d = tnpt_pkg::ST_SCAN_RD;
        end
      end

      tnpt_pkg::ST_SCAN_RD: begin
        if (i_q == count_q) begin
          state_d = tnpt_pkg::ST_DECIDE;
        end else begin
          ram_raddr = i_q[IdxW-1:0];
          state_d   = tnpt_pkg::ST_SCAN_LD;
        end
      end

      tnpt_pkg::ST_SCAN_LD: begin
        cur_t_d          = rd_time;
        cur_p_d          = rd_power;
        div_req.start    = 1'b1;
        div_req.dividend = rd_time;
        state_d          = tnpt_pkg::ST_SCAN_DIV;
      end

      tnpt_pkg::ST_SCAN_DIV: begin
        if (!div_busy) begin
          state_d = tnpt_pkg::ST_SCAN_CMP;
        end
      end

      tnpt_pkg::ST_SCAN_CMP: begin
        // A duplicate that is not stronger is dropped; all else compacts down.
        if (is_dup && !cur_stronger) begin
          gone_d = gone_q + CntW'(1);
        end else begin
          if (is_dup) begin
            stronger_d = 1'b1;
          end
          ram_we    = 1'b1;
          ram_waddr = kept_q[IdxW-1:0];
          ram_wdata = {cur_t_q, cur_p_q};
          if (!found_q && new_stronger) begin
            found_d = 1'b1;
            pos_d   = kept_q;
          end
          kept_d = kept_q + CntW'(1);
        end
        i_d     = i_q + CntW'(1);
        state_d = tnpt_pkg::ST_SCAN_RD;
      end

      tnpt_pkg::ST_DECIDE: begin
        count_d = kept_q;
        pos_d   = pos_eff;
        if ((stronger_q && (gone_q == '0)) || (pos_eff == CntMax)) begin
          state_d = tnpt_pkg::ST_OUT_RD;
        end else begin
          j_d     = (kept_q == CntMax) ? CntLast : kept_q;
          state_d = tnpt_pkg::ST_SHIFT_RD;
        end
      end

      tnpt_pkg::ST_SHIFT_RD: begin
        if (j_q == pos_q) begin
          state_d = tnpt_pkg::ST_INSERT;
        end else begin
          ram_raddr = j_prev[IdxW-1:0];
          state_d   = tnpt_pkg::ST_SHIFT_WR;
        end
      end

      tnpt_pkg::ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = j_q[IdxW-1:0];
        ram_wdata = ram_rdata;
        j_d       = j_prev;
        state_d   = tnpt_pkg::ST_SHIFT_RD;
      end

      tnpt_pkg::ST_INSERT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[IdxW-1:0];
        ram_wdata = {t_q, p_q};
        if (count_q != CntMax) begin
          count_d = count_q + CntW'(1);
        end
        ins_d   = 1'b1;
        state_d = tnpt_pkg::ST_OUT_RD;
      end

      tnpt_pkg::ST_OUT_RD: begin
        state_d = tnpt_pkg::ST_OUT_LD;
      end

      tnpt_pkg::ST_OUT_LD: begin
        // Hand over once the result register is free or being emptied.
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = tnpt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tnpt_pkg::ST_IDLE;
      end
    endcase
  end

  // Result register valid flag.
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tnpt_pkg::ST_IDLE;
      period_q    <= tnpt_pkg::PeriodReset;
      window_q    <= tnpt_pkg::WindowReset;
      i_q         <= '0;
      kept_q      <= '0;
      gone_q      <= '0;
      pos_q       <= '0;
      j_q         <= '0;
      count_q     <= '0;
      found_q     <= 1'b0;
      stronger_q  <= 1'b0;
      ins_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      kept_q      <= kept_d;
      gone_q      <= gone_d;
      pos_q       <= pos_d;
      j_q         <= j_d;
      count_q     <= count_d;
      found_q     <= found_d;
      stronger_q  <= stronger_d;
      ins_q       <= ins_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          tnpt_pkg::CFG_PERIOD_LEN: period_q <= cfg_data_i;
          tnpt_pkg::CFG_DUP_WINDOW: window_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers: request beat, scan entry and result beat.
  always_ff @(posedge clk_i) begin
    rn_q    <= rn_d;
    cur_t_q <= cur_t_d;
    cur_p_q <= cur_p_d;
    if (in_fire) begin
      req_q <= req_type_i;
      t_q   <= peak_time_i;
      p_q   <= peak_power_i;
      idx_q <= read_index_i;
    end
    if (out_load) begin
      ot_q <= rd_valid ? rd_time : '0;
      op_q <= rd_valid ? rd_power : '0;
      ov_q <= rd_valid;
      oc_q <= tnpt_pkg::CountW'(count_q);
      oi_q <= ins_q && (req_q == tnpt_pkg::REQ_OFFER);
      or_q <= tnpt_pkg::CountW'(gone_q);
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign entry_time_o    = ot_q;
  assign entry_power_o   = op_q;
  assign entry_valid_o   = ov_q;
  assign entry_count_o   = oc_q;
  assign peak_inserted_o = oi_q;
  assign peaks_removed_o = or_q;

endmodule

// ===== rtl/tnpt_checker.sv =====
// ----------------------------------------------------------------------------
// tnpt_checker
// Port-level checks of the peak table, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tnpt_checker #(
  parameter int unsigned MaxPeaks = tnpt_pkg::DefaultMaxPeaks
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [tnpt_pkg::TimeW-1:0]  entry_time_o,
  input logic [tnpt_pkg::PowerW-1:0] entry_power_o,
  input logic                        entry_valid_o,
  input logic [tnpt_pkg::CountW-1:0] entry_count_o,
  input logic                        peak_inserted_o,
  input logic [tnpt_pkg::CountW-1:0] peaks_removed_o
);

  // A stalled result beat holds its place and its time, power, count and removal fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(entry_time_o) &&
      $stable(entry_power_o) && $stable(entry_count_o) && $stable(peaks_removed_o))
    else $error("result beat changed while stalled");

  // A position past the end reads as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !entry_valid_o |-> entry_time_o == '0 && entry_power_o == '0)
    else $error("invalid entry carries nonzero data");

  // The table never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entry_count_o <= tnpt_pkg::CountW'(MaxPeaks))
    else $error("entry count exceeds table depth");

  // An inserted peak leaves the table non-empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && peak_inserted_o |-> entry_count_o != '0)
    else $error("insertion reported with an empty table");

endmodule

bind top_n_peak_table_with_period_dedup_unit tnpt_checker #(
  .MaxPeaks (MaxPeaks)
) u_tnpt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .entry_time_o    (entry_time_o),
  .entry_power_o   (entry_power_o),
  .entry_valid_o   (entry_valid_o),
  .entry_count_o   (entry_count_o),
  .peak_inserted_o (peak_inserted_o),
  .peaks_removed_o (peaks_removed_o)
);
